// File: sv/bcle_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcle_pkg
// Shared types and constants for the bounded circular list engine.
// ----------------------------------------------------------------------------
package bcle_pkg;

  // default sizing
  localparam int CAPACITY_DEF  = 32;
  localparam int DATA_BITS_DEF = 32;

  // fixed port widths
  localparam int CMD_W    = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 7;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_INS_END   = 3'd0,
    CMD_INS_FRONT = 3'd1,
    CMD_DEL_END   = 3'd2,
    CMD_DEL_FRONT = 3'd3,
    CMD_INS_AT    = 3'd4,
    CMD_DEL_AT    = 3'd5
  } cmd_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_BADPOS = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  // controller -> datapath commands
  typedef struct packed {
    logic capture;  // latch the incoming beat
    logic execute;  // apply the command, load the result register
  } ctrl_t;

endpackage : bcle_pkg
`default_nettype wire

// File: sv/bcle_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcle_ctrl
// Two-state sequencer: capture a command beat, then execute it once the
// result register is free or being drained.
// ----------------------------------------------------------------------------
module bcle_ctrl
  import bcle_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_stall_o,
  output logic       out_valid_o,
  input  wire logic  out_stall_i,
  output ctrl_t      ctrl_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d        = state_q;
    ctrl_o.capture = 1'b0;
    ctrl_o.execute = 1'b0;
    in_stall_o     = 1'b1;
    case (state_q)
      S_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          ctrl_o.capture = 1'b1;
          state_d        = S_EXEC;
        end
      end
      S_EXEC: begin
        // result register free or being drained this cycle
        if (!out_valid_q || !out_stall_i) begin
          ctrl_o.execute = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    out_valid_d = ctrl_o.execute | (out_valid_q & out_stall_i);
  end

  assign out_valid_o = out_valid_q;

endmodule : bcle_ctrl
`default_nettype wire

// File: sv/bcle_dpath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcle_dpath
// Row of shifting cells, element count, command decode and result register.
// ----------------------------------------------------------------------------
module bcle_dpath
  import bcle_pkg::*;
#(
  parameter int CAPACITY  = CAPACITY_DEF,
  parameter int DATA_BITS = DATA_BITS_DEF
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire ctrl_t                      ctrl_i,
  input  wire logic        [CMD_W-1:0]    cmd_i,
  input  wire logic signed [VALUE_W-1:0]  value_i,
  input  wire logic        [POS_W-1:0]    position_i,
  output logic             [STATUS_W-1:0] status_o,
  output logic signed      [VALUE_W-1:0]  removed_value_o,
  output logic             [COUNT_W-1:0]  element_count_o
);

  localparam int CntW   = $clog2(CAPACITY + 1);
  localparam int IdxW   = $clog2(CAPACITY);
  localparam int CmpW   = ((CntW > POS_W) ? CntW : POS_W) + 1;
  localparam int ExtW   = (DATA_BITS > VALUE_W) ? DATA_BITS : VALUE_W;

  // captured beat
  logic        [CMD_W-1:0]   cmd_q;
  logic signed [VALUE_W-1:0] value_q;
  logic        [POS_W-1:0]   pos_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.capture) begin
      cmd_q   <= cmd_i;
      value_q <= value_i;
      pos_q   <= position_i;
    end
  end

  logic [CntW-1:0] cnt_q, cnt_d;
  logic [DATA_BITS-1:0] cell_q [CAPACITY];
  logic [DATA_BITS-1:0] cell_d [CAPACITY];

  // decode
  logic              do_ins, do_del;
  logic [IdxW-1:0]   idx;
  status_e           status;
  logic              full, empty;
  logic [CmpW-1:0]   pos_c, cnt_c;
  logic [CntW-1:0]   cnt_m1;
  logic [POS_W-1:0]  pos_m1;
  logic [ExtW-1:0]   val_ext;
  logic [DATA_BITS-1:0] val_st;
  logic signed [DATA_BITS-1:0] rd_cell;
  logic [ExtW-1:0]   rd_ext;
  logic signed [VALUE_W-1:0] removed;

  assign full    = (cnt_q == CntW'(CAPACITY));
  assign empty   = (cnt_q == '0);
  assign pos_c   = CmpW'(pos_q);
  assign cnt_c   = CmpW'(cnt_q);
  assign cnt_m1  = cnt_q - 1'b1;
  assign pos_m1  = pos_q - 1'b1;
  assign val_ext = ExtW'(value_q);
  assign val_st  = val_ext[DATA_BITS-1:0];

  always_comb begin
    do_ins = 1'b0;
    do_del = 1'b0;
    idx    = '0;
    status = ST_OK;
    case (cmd_e'(cmd_q))
      CMD_INS_END: begin
        if (full) status = ST_FULL;
        else begin
          do_ins = 1'b1;
          idx    = cnt_q[IdxW-1:0];
        end
      end
      CMD_INS_FRONT: begin
        if (full) status = ST_FULL;
        else do_ins = 1'b1;
      end
      CMD_DEL_END: begin
        if (empty) status = ST_EMPTY;
        else begin
          do_del = 1'b1;
          idx    = cnt_m1[IdxW-1:0];
        end
      end
      CMD_DEL_FRONT: begin
        if (empty) status = ST_EMPTY;
        else do_del = 1'b1;
      end
      CMD_INS_AT: begin
        // empty is checked ahead of full and position
        if (empty) status = ST_EMPTY;
        else if (full) status = ST_FULL;
        else if (pos_c == '0 || pos_c > cnt_c + 1'b1) status = ST_BADPOS;
        else begin
          do_ins = 1'b1;
          idx    = pos_m1[IdxW-1:0];
        end
      end
      CMD_DEL_AT: begin
        if (empty) status = ST_EMPTY;
        else if (pos_c == '0 || pos_c > cnt_c) status = ST_BADPOS;
        else begin
          do_del = 1'b1;
          idx    = pos_m1[IdxW-1:0];
        end
      end
      default: begin
        status = ST_OK;  // unused codes: no change
      end
    endcase
  end

  // each cell picks its own, its left or its right neighbor, or the new value
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [IdxW-1:0] Pos = IdxW'(i);
    if (i == 0) begin : g_first
      always_comb begin
        cell_d[i] = cell_q[i];
        if (do_ins && Pos == idx) cell_d[i] = val_st;
        else if (do_del && Pos >= idx) cell_d[i] = cell_q[i+1];
      end
    end else if (i == CAPACITY - 1) begin : g_last
      always_comb begin
        cell_d[i] = cell_q[i];
        if (do_ins && Pos == idx) cell_d[i] = val_st;
        else if (do_ins && Pos > idx) cell_d[i] = cell_q[i-1];
      end
    end else begin : g_mid
      always_comb begin
        cell_d[i] = cell_q[i];
        if (do_ins && Pos == idx) cell_d[i] = val_st;
        else if (do_ins && Pos > idx) cell_d[i] = cell_q[i-1];
        else if (do_del && Pos >= idx) cell_d[i] = cell_q[i+1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.execute) begin
      cell_q <= cell_d;
    end
  end

  assign rd_cell = cell_q[idx];
  assign rd_ext  = ExtW'(rd_cell);
  assign removed = do_del ? rd_ext[VALUE_W-1:0] : '0;

  always_comb begin
    cnt_d = cnt_q;
    if (do_ins) cnt_d = cnt_q + 1'b1;
    else if (do_del) cnt_d = cnt_m1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ctrl_i.execute) begin
      cnt_q <= cnt_d;
    end
  end

  // result register
  always_ff @(posedge clk_i) begin
    if (ctrl_i.execute) begin
      status_o        <= status;
      removed_value_o <= removed;
      element_count_o <= COUNT_W'(cnt_d);
    end
  end

endmodule : bcle_dpath
`default_nettype wire

// File: sv/bounded_circular_list_engine.sv
`default_nettype none
// Flow: a command beat is captured, then applied in the execute state and
//   its result loaded into the result register; a new beat is taken only
//   after that; a stalled result holds the execute state back.
// Reset: clears the element count and result valid; cells are not cleared,
//   only entries below the count are ever read.
// ----------------------------------------------------------------------------
// bounded_circular_list_engine
// Ordered ring of up to CAPACITY signed values with end, front and
// positional insert and delete.
// ----------------------------------------------------------------------------
module bounded_circular_list_engine
  import bcle_pkg::*;
#(
  parameter int CAPACITY  = CAPACITY_DEF,  // 2..64
  parameter int DATA_BITS = DATA_BITS_DEF  // 1..64
) (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // command channel
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic        [CMD_W-1:0]    cmd_i,
  input  wire logic signed [VALUE_W-1:0]  value_i,
  input  wire logic        [POS_W-1:0]    position_i,
  // result channel
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic             [STATUS_W-1:0] status_o,
  output logic signed      [VALUE_W-1:0]  removed_value_o,
  output logic             [COUNT_W-1:0]  element_count_o
);

  ctrl_t ctrl;

  // Sequencer: IDLE takes a beat, EXEC applies it when the result
  // register can take the new result.
  bcle_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .ctrl_o      (ctrl)
  );

  // Datapath: the cells at and beyond the position shift left or right in
  // parallel in the execute state, so any insert or delete is applied at once.
  bcle_dpath #(
    .CAPACITY  (CAPACITY),
    .DATA_BITS (DATA_BITS)
  ) u_dpath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .ctrl_i          (ctrl),
    .cmd_i           (cmd_i),
    .value_i         (value_i),
    .position_i      (position_i),
    .status_o        (status_o),
    .removed_value_o (removed_value_o),
    .element_count_o (element_count_o)
  );

endmodule : bounded_circular_list_engine
`default_nettype wire

// File: sv/bcle_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bcle_checker
// Port-level checks for the list engine, bound to the top level.
// ----------------------------------------------------------------------------
module bcle_checker
  import bcle_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       in_valid_i,
  input wire logic                       in_stall_o,
  input wire logic                       out_valid_o,
  input wire logic                       out_stall_i,
  input wire logic        [STATUS_W-1:0] status_o,
  input wire logic signed [VALUE_W-1:0]  removed_value_o,
  input wire logic        [COUNT_W-1:0]  element_count_o
);

  // stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(status_o)
      && $stable(removed_value_o) && $stable(element_count_o))
    else $error("stalled result beat changed");

  // one command in flight: busy right after a beat is taken
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("second beat taken while executing");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> element_count_o <= COUNT_W'(CAPACITY))
    else $error("element count above capacity");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> removed_value_o == '0)
    else $error("rejected command reports a removed value");

  a_full_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL || status_o == ST_EMPTY) |->
      (status_o == ST_FULL && element_count_o == COUNT_W'(CAPACITY))
      || (status_o == ST_EMPTY && element_count_o == '0))
    else $error("full or empty status does not match the count");

endmodule : bcle_checker

bind bounded_circular_list_engine bcle_checker #(.CAPACITY(CAPACITY)) u_bcle_checker (.*);
`default_nettype wire
